// ===== hw/rtl/stjm_pkg.sv =====
// shared types and constants of the sorted theta join matcher
package stjm_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    localparam int POS_W   = 16;
    localparam int MODE_W  = 3;
    localparam int OP_W    = 2;
    localparam logic [POS_W-1:0] MAX_POS = {POS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_STORE = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_EQ = 3'd0,
        MODE_GT = 3'd1,
        MODE_GE = 3'd2,
        MODE_LT = 3'd3,
        MODE_LE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// ===== hw/rtl/stjm_store.sv =====
// key store: one write port, one registered read port
module stjm_store import stjm_pkg::*; #(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int DATA_W = KEY_BITS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sorted_theta_join_matcher_unit.sv =====
// top level of the sorted theta join matcher
//
// channel   dir  tdata                                tuser      tlast
// s_        in   key[KEY_BITS-1:0] (zero padded)      opcode     -
// m_        out  left_position[15:0], right_pos[31:16] -         last_match
// cfg_wr_*  in   compare_mode[2:0]                    -          -
//
// store and clear words are done in the accept cycle, and so is a probe of an empty store; any other
// probe goes through the accept cycle, a scan state that reads each stored key in turn
// from the single read port of the key store, and a closing flush state for the final pair
// reset clears the store count, the probe count, the mode and the output valid flag
// a full output register with m_tready low stalls the scan or the flush in place when a pair is due to be pushed

module sorted_theta_join_matcher_unit import stjm_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int S_DATA_W    = ((KEY_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [MODE_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key
    input  logic [OP_W-1:0]     s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*POS_W-1:0]  m_tdata,   // left_position, right_position
    output logic                m_tlast    // last_match
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [KEY_BITS-1:0] probe_key_reg, probe_key_next;
    logic                probe_left_reg, probe_left_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]    pend_spos_reg, pend_spos_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_lpos_reg, out_lpos_next;
    logic [POS_W-1:0]    out_rpos_reg, out_rpos_next;
    logic                out_last_reg, out_last_next;

    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [KEY_BITS-1:0] rd_data;

    logic                s_accept;
    opcode_t             op;
    logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                hit;
    logic                can_push;
    logic                need_push;
    logic                last_idx;
    logic [POS_W-1:0]    cur_spos;

    stjm_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (KEY_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata[KEY_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign op       = opcode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign can_push = !out_valid_reg || m_tready;
    assign cur_spos = POS_W'(idx_reg) + POS_W'(1);
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        cmp_a = probe_left_reg ? probe_key_reg : rd_data;
        cmp_b = probe_left_reg ? rd_data : probe_key_reg;
        case (mode_reg)
            MODE_EQ: hit = (cmp_a == cmp_b);
            MODE_GT: hit = (cmp_a >  cmp_b);
            MODE_GE: hit = (cmp_a >= cmp_b);
            MODE_LT: hit = (cmp_a <  cmp_b);
            default: hit = (cmp_a <= cmp_b);
        endcase
    end

    assign need_push = hit && pend_valid_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        probe_cnt_next  = probe_cnt_reg;
        probe_key_next  = probe_key_reg;
        probe_left_next = probe_left_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_spos_next  = pend_spos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_lpos_next   = out_lpos_reg;
        out_rpos_next   = out_rpos_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (op)
                        OP_STORE: begin
                            if (count_reg < DEPTH_CNT) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PROBE: begin
                            if (probe_cnt_reg != MAX_POS) begin
                                probe_cnt_next = probe_cnt_reg + POS_W'(1);
                            end
                            probe_key_next  = s_tdata[KEY_BITS-1:0];
                            probe_left_next = (mode_reg <= MODE_W'(MODE_GE));
                            pend_valid_next = 1'b0;
                            idx_next        = '0;
                            if (count_reg != '0) begin
                                rd_en      = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            count_next     = '0;
                            probe_cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!need_push || can_push) begin
                    if (need_push) begin
                        out_valid_next = 1'b1;
                        out_lpos_next  = probe_left_reg ? probe_cnt_reg : pend_spos_reg;
                        out_rpos_next  = probe_left_reg ? pend_spos_reg : probe_cnt_reg;
                        out_last_next  = 1'b0;
                    end
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_spos_next  = cur_spos;
                    end
                    if (last_idx) begin
                        state_next = ST_FLUSH;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (can_push) begin
                    out_valid_next  = 1'b1;
                    out_lpos_next   = probe_left_reg ? probe_cnt_reg : pend_spos_reg;
                    out_rpos_next   = probe_left_reg ? pend_spos_reg : probe_cnt_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_W'(MODE_EQ);
            count_reg      <= '0;
            probe_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            probe_cnt_reg  <= probe_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        probe_key_reg  <= probe_key_next;
        probe_left_reg <= probe_left_next;
        idx_reg        <= idx_next;
        pend_spos_reg  <= pend_spos_next;
        out_lpos_reg   <= out_lpos_next;
        out_rpos_reg   <= out_rpos_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rpos_reg, out_lpos_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/stjm_checker.sv =====
// port checker of the sorted theta join matcher and its bind
module stjm_checker import stjm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [2*POS_W-1:0] m_tdata,
    input logic               m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[POS_W-1:0] != '0) && (m_tdata[2*POS_W-1:POS_W] != '0))
        else $error("result position is zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind sorted_theta_join_matcher_unit stjm_checker u_stjm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
